### hdl/onci_pkg.sv
// ----------------------------------------------------------------------------
// onci_pkg: shared types and constants for obstacle neighbor cost inflation
// Field widths, register map codes, reset values and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package onci_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int COST_BITS_DEF   = 24;

  // Field and register widths
  localparam int COLS_W     = 7;
  localparam int ROWS_W     = 13;
  localparam int PEN_W      = 24;
  localparam int BASE_W     = 24;
  localparam int NEWCOST_W  = 24;
  localparam int CNT_W      = 4;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKED_PENALTY = 2'd2;

  localparam logic [COLS_W-1:0] GRID_COLUMNS_RST    = 7'd64;
  localparam logic [ROWS_W-1:0] GRID_ROWS_RST       = 13'd64;
  localparam logic [PEN_W-1:0]  BLOCKED_PENALTY_RST = 24'd256;

  // Result queue depth (power of two)
  localparam int RES_FIFO_DEPTH = 8;

  typedef struct packed {
    logic [NEWCOST_W-1:0] new_cost;
    logic [CNT_W-1:0]     blocked_count;
    logic                 last_cell;
  } result_t;

endpackage

`default_nettype wire

### hdl/onci_if.sv
// ----------------------------------------------------------------------------
// onci_if: valid/ready channels for cell items and inflated cost results
// One interface per channel direction; payload fields travel with the handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface onci_in_if;
  import onci_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic              cell_blocked;
  logic [BASE_W-1:0] base_cost;

  modport source (output valid, output cmd, output cell_blocked, output base_cost,
                  input ready);
  modport sink   (input valid, input cmd, input cell_blocked, input base_cost,
                  output ready);
endinterface

interface onci_out_if;
  import onci_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [NEWCOST_W-1:0] new_cost;
  logic [CNT_W-1:0]     blocked_count;
  logic                 last_cell;

  modport source (output valid, output new_cost, output blocked_count, output last_cell,
                  input ready);
  modport sink   (input valid, input new_cost, input blocked_count, input last_cell,
                  output ready);
endinterface

`default_nettype wire

### hdl/obstacle_neighbor_cost_inflation.sv
// ----------------------------------------------------------------------------
// obstacle_neighbor_cost_inflation: 3x3 blocked-neighbor cost inflation
// One cell per cycle while the result queue has room; set by the line buffer RAM RMW.
// A result follows the item one row plus one cell on (one row on in the last column).
// Reset clears counters, pipeline and result queue; the line buffer is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obstacle_neighbor_cost_inflation #(
  parameter int MAX_COLUMNS = onci_pkg::MAX_COLUMNS_DEF,
  parameter int COST_BITS   = onci_pkg::COST_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  onci_in_if.sink                              in_item,
  onci_out_if.source                           out_result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [onci_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [onci_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [onci_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import onci_pkg::*;

  localparam int COL_W    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int LW       = COST_BITS + 2;
  localparam int PROD_W   = COST_BITS + CNT_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int FIFO_AW  = $clog2(RES_FIFO_DEPTH);
  localparam int FIFO_CW  = FIFO_AW + 1;
  localparam int RESV_W   = FIFO_CW + 1;
  localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

  typedef struct packed {
    logic [COL_W-1:0]     col;
    logic                 blk;
    logic [COST_BITS-1:0] cost;
    logic                 has_a;     // releases the cell one row up, one column left
    logic                 has_b;     // releases the cell one row up, same column
    logic                 top_ok;
    logic                 left1_ok;
    logic                 left2_ok;
    logic                 last;
  } s1_t;

  function automatic logic [CNT_W-1:0] ones3(input logic [2:0] v);
    return CNT_W'(v[0]) + CNT_W'(v[1]) + CNT_W'(v[2]);
  endfunction

  function automatic logic [COST_BITS-1:0] inflate(input logic [COST_BITS-1:0] base,
                                                   input logic [COST_BITS-1:0] pen,
                                                   input logic [CNT_W-1:0]     cnt);
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;
    prod = PROD_W'(pen) * PROD_W'(cnt);
    sum  = SUM_W'(base) + SUM_W'(prod);
    if (sum > SUM_W'(COST_MAX)) begin
      return COST_MAX;
    end
    return sum[COST_BITS-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [COLS_W-1:0]    grid_columns_r;
  logic [ROWS_W-1:0]    grid_rows_r;
  logic [PEN_W-1:0]     blocked_penalty_r;
  logic                 cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic                 geom_wr;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign geom_wr = cfg_wr && ((cfg_idx == REG_GRID_COLUMNS) || (cfg_idx == REG_GRID_ROWS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_columns_r    <= GRID_COLUMNS_RST;
      grid_rows_r       <= GRID_ROWS_RST;
      blocked_penalty_r <= BLOCKED_PENALTY_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GRID_COLUMNS:    grid_columns_r    <= pwdata[COLS_W-1:0];
        REG_GRID_ROWS:       grid_rows_r       <= pwdata[ROWS_W-1:0];
        REG_BLOCKED_PENALTY: blocked_penalty_r <= pwdata[PEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_GRID_COLUMNS:    prdata = CFG_DATA_W'(grid_columns_r);
      REG_GRID_ROWS:       prdata = CFG_DATA_W'(grid_rows_r);
      REG_BLOCKED_PENALTY: prdata = CFG_DATA_W'(blocked_penalty_r);
      default:             prdata = '0;
    endcase
  end

  // Effective geometry
  logic [COL_W-1:0]  col_last;
  logic [ROWS_W-1:0] nrows_eff;

  always_comb begin
    if (grid_columns_r == '0) begin
      col_last = '0;
    end else if (32'(grid_columns_r) > 32'(MAX_COLUMNS)) begin
      col_last = COL_W'(MAX_COLUMNS - 1);
    end else begin
      col_last = COL_W'(32'(grid_columns_r) - 32'd1);
    end
  end

  assign nrows_eff = (grid_rows_r == '0) ? ROWS_W'(1) : grid_rows_r;

  // --------------------------------------------------------------------------
  // Raster position counters
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROWS_W-1:0] row_r, row_nxt;
  logic              in_fire;

  assign in_fire = in_item.valid & in_item.ready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (geom_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (col_r == col_last) begin
        col_nxt = '0;
        row_nxt = (row_r == nrows_eff) ? '0 : row_r + ROWS_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 0 decode: position and cmd decide cell or pad
  logic is_cell;
  s1_t  s0;

  assign is_cell = (row_r < nrows_eff) && !in_item.cmd;

  always_comb begin
    s0.col      = col_r;
    s0.blk      = is_cell & in_item.cell_blocked;
    s0.cost     = is_cell ? COST_BITS'(in_item.base_cost) : '0;
    s0.has_a    = (row_r != '0) && (col_r != '0);
    s0.has_b    = (row_r != '0) && (col_r == col_last);
    s0.top_ok   = (row_r > ROWS_W'(1));
    s0.left1_ok = (col_r != '0);
    s0.left2_ok = (col_r > COL_W'(1));
    s0.last     = (row_r == nrows_eff);
  end

  // --------------------------------------------------------------------------
  // Line buffer: per column {blocked row-1, blocked row-2, cost row-1}
  // --------------------------------------------------------------------------
  logic [LW-1:0] line_mem [MAX_COLUMNS];
  logic [LW-1:0] rdata_r;
  logic [LW-1:0] fwd_word_r;
  logic          fwd_hit_r;
  logic          s1_valid_r;
  s1_t           s1_r;
  logic [LW-1:0] rd_word;
  logic [LW-1:0] wdata;
  logic [2:0]    c0;          // {top, mid, bottom} of the current column
  logic [COST_BITS-1:0] cost1;

  assign rd_word = fwd_hit_r ? fwd_word_r : rdata_r;
  assign cost1   = rd_word[COST_BITS-1:0];
  assign c0      = {rd_word[LW-2] & s1_r.top_ok, rd_word[LW-1], s1_r.blk};
  assign wdata   = {s1_r.blk, rd_word[LW-1], s1_r.cost};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rdata_r <= line_mem[col_r];
    end
    if (s1_valid_r) begin
      line_mem[s1_r.col] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    s1_r       <= s0;
    fwd_word_r <= wdata;
  end

  // Forward the word written back in the same edge as the read of that column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
      fwd_hit_r  <= in_fire && s1_valid_r && (s1_r.col == col_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: 3x3 window and neighbor counts
  // --------------------------------------------------------------------------
  logic [2:0]           win1_r, win2_r;
  logic [COST_BITS-1:0] win1_cost_r;
  logic [CNT_W-1:0]     cnt_a, cnt_b;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      win2_r      <= win1_r;
      win1_r      <= c0;
      win1_cost_r <= cost1;
    end
  end

  assign cnt_a = (s1_r.left2_ok ? ones3(win2_r) : '0) + CNT_W'(win1_r[2])
               + CNT_W'(win1_r[0]) + ones3(c0);
  assign cnt_b = (s1_r.left1_ok ? ones3(win1_r) : '0) + CNT_W'(c0[2]) + CNT_W'(c0[0]);

  logic                 s2_a_v_r, s2_b_v_r;
  logic [COST_BITS-1:0] s2_a_cost_r, s2_b_cost_r;
  logic [CNT_W-1:0]     s2_a_cnt_r, s2_b_cnt_r;
  logic                 s2_b_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_a_v_r <= 1'b0;
      s2_b_v_r <= 1'b0;
    end else begin
      s2_a_v_r <= s1_valid_r & s1_r.has_a;
      s2_b_v_r <= s1_valid_r & s1_r.has_b;
    end
  end

  always_ff @(posedge clk) begin
    s2_a_cost_r <= win1_cost_r;
    s2_a_cnt_r  <= cnt_a;
    s2_b_cost_r <= cost1;
    s2_b_cnt_r  <= cnt_b;
    s2_b_last_r <= s1_r.last;
  end

  // --------------------------------------------------------------------------
  // Stage 2: inflate, saturate, push into the result queue
  // --------------------------------------------------------------------------
  logic [COST_BITS-1:0] pen;
  result_t              res_a, res_b;

  assign pen = COST_BITS'(blocked_penalty_r);

  always_comb begin
    res_a.new_cost      = NEWCOST_W'(inflate(s2_a_cost_r, pen, s2_a_cnt_r));
    res_a.blocked_count = s2_a_cnt_r;
    res_a.last_cell     = 1'b0;
    res_b.new_cost      = NEWCOST_W'(inflate(s2_b_cost_r, pen, s2_b_cnt_r));
    res_b.blocked_count = s2_b_cnt_r;
    res_b.last_cell     = s2_b_last_r;
  end

  result_t              fifo_mem_r [RES_FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [FIFO_CW-1:0]   cnt_r, cnt_nxt;
  logic                 pop;
  logic [RESV_W-1:0]    resv;
  result_t              head;

  assign pop      = out_result.valid & out_result.ready;
  assign wptr_nxt = wptr_r + FIFO_AW'(s2_a_v_r) + FIFO_AW'(s2_b_v_r);
  assign rptr_nxt = rptr_r + FIFO_AW'(pop);
  assign cnt_nxt  = cnt_r + FIFO_CW'(s2_a_v_r) + FIFO_CW'(s2_b_v_r) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (s2_a_v_r) begin
      fifo_mem_r[wptr_r] <= res_a;
    end
    if (s2_b_v_r) begin
      fifo_mem_r[s2_a_v_r ? wptr_r + FIFO_AW'(1) : wptr_r] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold off input unless every in-flight item can land its results
  assign resv = RESV_W'(cnt_r) + (s1_valid_r ? RESV_W'(2) : '0)
              + RESV_W'(s2_a_v_r) + RESV_W'(s2_b_v_r);
  assign in_item.ready = (resv <= RESV_W'(RES_FIFO_DEPTH - 2));

  assign head                     = fifo_mem_r[rptr_r];
  assign out_result.valid         = (cnt_r != '0);
  assign out_result.new_cost      = head.new_cost;
  assign out_result.blocked_count = head.blocked_count;
  assign out_result.last_cell     = head.last_cell;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CW'(RES_FIFO_DEPTH))
    else $error("result queue overflow");

  a_last_cell_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_result.valid && out_result.last_cell) |-> (out_result.blocked_count <= CNT_W'(3)))
    else $error("corner cell reports more than three blocked neighbors");

  a_fwd_single_col: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> (s1_valid_r && (col_last == '0)))
    else $error("line buffer forward outside a single-column grid");

endmodule

`default_nettype wire
